// File: rtl/bhcs_pkg.sv
// Shared types, constants and commutation tables for the Hall commutation block.
// No dependencies; used by bhcs_step and bldc_hall_commutation_speed.
`timescale 1ns / 1ps
`default_nettype none

package bhcs_pkg;

	localparam int DUTY_W           = 7;
	localparam int SPEED_W          = 16;
	localparam int HALL_W           = 3;
	localparam int CMD_W            = 16;
	localparam int MAX_DUTY         = 100;
	localparam int TICKS_PER_WINDOW = 10;

	typedef logic [DUTY_W-1:0]  duty_t;
	typedef logic [SPEED_W-1:0] speed_t;
	typedef logic [HALL_W-1:0]  hall_t;
	typedef logic [2:0]         pat_t;

	typedef enum logic {
		OP_HALL = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	// Phase pattern: bit 2 drives phase A, bit 1 phase B, bit 0 phase C.
	localparam pat_t PAT_NONE     = 3'd0;
	localparam pat_t PAT_ROTATION = 3'd6;

	localparam pat_t TAB_CW  [8] = '{3'd0, 3'd5, 3'd6, 3'd4, 3'd3, 3'd1, 3'd2, 3'd0};
	localparam pat_t TAB_CCW [8] = '{3'd0, 3'd2, 3'd1, 3'd3, 3'd4, 3'd6, 3'd5, 3'd0};

	// Everything the step logic needs from the command register.
	typedef struct packed {
		logic  dir_ccw;
		duty_t duty;
	} cmd_t;

	typedef struct packed {
		speed_t measured_speed;
		duty_t  duty_c;
		duty_t  duty_b;
		duty_t  duty_a;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/bhcs_step.sv
// Commutation and speed-window state: applies one word per fire and holds the result.
// Depends on bhcs_pkg for tables, types and the command struct.
`timescale 1ns / 1ps
`default_nettype none

module bhcs_step #(
	parameter int TICKS_PER_WINDOW = bhcs_pkg::TICKS_PER_WINDOW
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        fire,
	input  wire bhcs_pkg::opcode_t     opcode,
	input  wire bhcs_pkg::hall_t       hall_code,
	input  wire bhcs_pkg::cmd_t        cmd,
	output bhcs_pkg::result_t          result
);

	localparam int TICK_W = (TICKS_PER_WINDOW > 1) ? $clog2(TICKS_PER_WINDOW) : 1;

	bhcs_pkg::duty_t     duty_a_q, duty_b_q, duty_c_q;
	bhcs_pkg::speed_t    rotation_q, latched_q;
	logic [TICK_W-1:0]   tick_q;
	bhcs_pkg::pat_t      pat;
	logic                window_end;

	always_comb begin
		pat        = cmd.dir_ccw ? bhcs_pkg::TAB_CCW[hall_code] : bhcs_pkg::TAB_CW[hall_code];
		window_end = (tick_q == TICK_W'(TICKS_PER_WINDOW - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_a_q   <= '0;
			duty_b_q   <= '0;
			duty_c_q   <= '0;
			rotation_q <= '0;
			latched_q  <= '0;
			tick_q     <= '0;
		end else if (fire) begin
			if (opcode == bhcs_pkg::OP_HALL) begin
				// Invalid Hall codes map to no pattern: hold the phases.
				if (pat != bhcs_pkg::PAT_NONE) begin
					duty_a_q <= pat[2] ? cmd.duty : '0;
					duty_b_q <= pat[1] ? cmd.duty : '0;
					duty_c_q <= pat[0] ? cmd.duty : '0;
					if (pat == bhcs_pkg::PAT_ROTATION)
						rotation_q <= rotation_q + 1'b1;
				end
			end else begin
				if (window_end) begin
					tick_q     <= '0;
					latched_q  <= rotation_q;
					rotation_q <= '0;
				end else begin
					tick_q <= tick_q + 1'b1;
				end
			end
		end
	end

	assign result = '{measured_speed: latched_q, duty_c: duty_c_q,
			duty_b: duty_b_q, duty_a: duty_a_q};

endmodule

`default_nettype wire

// File: rtl/bldc_hall_commutation_speed.sv
// Six-step Hall commutation with rotation-speed window, streaming in and out.
// Depends on bhcs_pkg and bhcs_step.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   s_*      | in        | tuser: opcode; tdata: hall_code
//   m_*      | out       | tdata: duty_phase_a/b/c, measured_speed
//   cfg_*    | in        | speed_command, written when cfg_wen is high
//
// One word per cycle sustained while m_tready stays high; an accepted word passes the input
// register, then the state/result register, before it shows on m_tvalid.
// The commutation state registers double as the result register, so a word is
// applied only when the previous result has been taken or is being taken.
// Reset clears duties, counters, command and direction (clockwise).
// A stalled m_tready holds both stages; s_tready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module bldc_hall_commutation_speed #(
	parameter int TICKS_PER_WINDOW = bhcs_pkg::TICKS_PER_WINDOW
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [2:0] hall_code, [7:3] zero
	input  wire         s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [6:0] duty_phase_a, [13:7] duty_phase_b,
	                               // [20:14] duty_phase_c, [36:21] measured_speed,
	                               // [39:37] zero
	input  wire         cfg_wen,
	input  wire  [15:0] cfg_wdata
);

	logic                 valid_s1;
	bhcs_pkg::opcode_t    opcode_s1;
	bhcs_pkg::hall_t      hall_s1;
	logic                 out_valid_q;
	bhcs_pkg::cmd_t       cmd_q;
	bhcs_pkg::result_t    result;
	logic                 fire;
	logic                 s_accept;
	logic [15:0]          cmd_mag;
	bhcs_pkg::duty_t      cmd_duty;

	assign fire     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign s_accept = s_tvalid && s_tready;

	// Magnitude of the signed command; the most negative value reads as 32768.
	always_comb begin
		cmd_mag  = cfg_wdata[15] ? (~cfg_wdata + 16'd1) : cfg_wdata;
		cmd_duty = (cmd_mag > 16'(bhcs_pkg::MAX_DUTY)) ?
			bhcs_pkg::duty_t'(bhcs_pkg::MAX_DUTY) : cmd_mag[bhcs_pkg::DUTY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
		end else if (cfg_wen) begin
			cmd_q.duty <= cmd_duty;
			// Zero command keeps the previous direction.
			if (cfg_wdata[15])
				cmd_q.dir_ccw <= 1'b1;
			else if (cfg_wdata != '0)
				cmd_q.dir_ccw <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			opcode_s1 <= bhcs_pkg::opcode_t'(s_tuser);
			hall_s1   <= s_tdata[bhcs_pkg::HALL_W-1:0];
		end
	end

	bhcs_step #(
		.TICKS_PER_WINDOW(TICKS_PER_WINDOW)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.opcode    (opcode_s1),
		.hall_code (hall_s1),
		.cmd       (cmd_q),
		.result    (result)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, result};

endmodule

`default_nettype wire

// File: sim/commutation_checker.sv
// Watches the Hall/tick input stream, the command port and the duty/speed output stream.
// Predicts every output word from its own commutation model and compares field by field.
// Depends on bhcs_pkg for the opcode enum, field types and result layout.
`timescale 1ns / 1ps

module commutation_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [7:0]  s_tdata,
	input  wire         s_tuser,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [39:0] m_tdata,
	input  wire         cfg_wen,
	input  wire  [15:0] cfg_wdata,
	output int          errors,
	output int          outstanding
);

	// Phase pattern per Hall code, code 0 in the lowest three bits.
	localparam logic [23:0] CW_PATTERNS  = {3'd0, 3'd2, 3'd1, 3'd3, 3'd4, 3'd6, 3'd5, 3'd0};
	localparam logic [23:0] CCW_PATTERNS = {3'd0, 3'd5, 3'd6, 3'd4, 3'd3, 3'd1, 3'd2, 3'd0};

	logic [15:0]         speed_cmd;
	bit                  ccw;
	bhcs_pkg::duty_t     duty_a, duty_b, duty_c;
	int unsigned         ticks;
	bhcs_pkg::speed_t    rotations, latched;
	bhcs_pkg::result_t   expected_words[$];

	initial begin
		errors      = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string field, input longint got, input longint want);
		errors++;
		$display("%0t ns: %s is %0d, expected %0d", $time, field, got, want);
	endtask

	function automatic bhcs_pkg::result_t advance_motor(bhcs_pkg::opcode_t op,
			bhcs_pkg::hall_t code);
		bhcs_pkg::pat_t      pattern;
		int unsigned         magnitude;
		bhcs_pkg::duty_t     duty;
		bhcs_pkg::result_t   word;
		if (op == bhcs_pkg::OP_HALL) begin
			pattern   = ccw ? CCW_PATTERNS[code*3 +: 3] : CW_PATTERNS[code*3 +: 3];
			// two's-complement magnitude, so the most negative command saturates too
			magnitude = speed_cmd[15] ? 32'd65536 - 32'(speed_cmd) : 32'(speed_cmd);
			duty      = (magnitude > bhcs_pkg::MAX_DUTY) ?
				bhcs_pkg::duty_t'(bhcs_pkg::MAX_DUTY) : bhcs_pkg::duty_t'(magnitude);
			if (pattern != bhcs_pkg::PAT_NONE) begin
				duty_a = pattern[2] ? duty : '0;
				duty_b = pattern[1] ? duty : '0;
				duty_c = pattern[0] ? duty : '0;
				if (pattern == bhcs_pkg::PAT_ROTATION)
					rotations = rotations + 1'b1;
			end
		end else begin
			ticks++;
			if (ticks >= bhcs_pkg::TICKS_PER_WINDOW) begin
				ticks     = 0;
				latched   = rotations;
				rotations = '0;
			end
		end
		word.duty_a         = duty_a;
		word.duty_b         = duty_b;
		word.duty_c         = duty_c;
		word.measured_speed = latched;
		return word;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bhcs_pkg::result_t want, got;
		if (!arst_n) begin
			speed_cmd = '0;
			ccw       = 1'b0;
			duty_a    = '0;
			duty_b    = '0;
			duty_c    = '0;
			ticks     = 0;
			rotations = '0;
			latched   = '0;
			expected_words.delete();
			outstanding = 0;
		end else begin
			if (cfg_wen) begin
				speed_cmd = cfg_wdata;
				// zero command keeps the previous direction
				if (cfg_wdata[15])
					ccw = 1'b1;
				else if (cfg_wdata != '0)
					ccw = 1'b0;
			end
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("output word with nothing pending, m_tdata", m_tdata, 0);
				end else begin
					want = expected_words.pop_front();
					got  = bhcs_pkg::result_t'(m_tdata[36:0]);
					if (got.duty_a !== want.duty_a)
						report_mismatch("duty_phase_a", got.duty_a, want.duty_a);
					if (got.duty_b !== want.duty_b)
						report_mismatch("duty_phase_b", got.duty_b, want.duty_b);
					if (got.duty_c !== want.duty_c)
						report_mismatch("duty_phase_c", got.duty_c, want.duty_c);
					if (got.measured_speed !== want.measured_speed)
						report_mismatch("measured_speed", got.measured_speed,
							want.measured_speed);
				end
			end
			if (s_tvalid && s_tready)
				expected_words.push_back(advance_motor(bhcs_pkg::opcode_t'(s_tuser),
					s_tdata[2:0]));
			outstanding = expected_words.size();
		end
	end

endmodule

// File: sim/bldc_hall_commutation_speed_test.sv
// Testbench top: drives Hall events, timer ticks and speed commands into the block
// and random backpressure on its output. Depends on bhcs_pkg, the block and commutation_checker.
`timescale 1ns / 1ps

module bldc_hall_commutation_speed_test;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASES        = 12;
	localparam int PHASE_WORDS   = 60;
	// one electrical turn in clockwise order, first code in the lowest bits
	localparam logic [17:0] TURN = {3'd3, 3'd2, 3'd6, 3'd4, 3'd5, 3'd1};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [7:0]  s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tready  = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [15:0] cfg_wdata = '0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [39:0] m_tdata;
	int          fail_count;
	int          awaiting;
	int          cycles    = 0;
	bit          send_burst;
	bit          take_burst;

	bldc_hall_commutation_speed uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	commutation_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.errors      (fail_count),
		.outstanding (awaiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Output side: stall a random number of cycles before taking each word.
	initial begin
		int stall;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = take_burst ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic send_word(input bhcs_pkg::opcode_t op, input bhcs_pkg::hall_t code);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  <= op;
		s_tdata  <= {5'b0, code};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Hold off until every pending word has drained, then load a new command.
	task automatic write_command(input logic [15:0] value);
		s_tvalid <= 1'b0;
		while (awaiting != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_wdata <= value;
		cfg_wen   <= 1'b1;
		@(negedge clk);
		cfg_wen   <= 1'b0;
	endtask

	initial begin
		logic [15:0] plan [PHASES];
		int          position;
		bit          forward;
		int          pick;
		plan = '{16'(-100), 16'd0, 16'h8000, 16'h7FFF, 16'd50, 16'd0,
			16'd1, 16'hFFFF, 16'd101, 16'(-101), 16'd0, 16'd0};
		plan[10] = 16'($urandom);
		plan[11] = 16'($urandom_range(0, 200) - 100);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero command straight out of reset: every code, all duties stay zero
		for (int code = 0; code < 8; code++)
			send_word(bhcs_pkg::OP_HALL, bhcs_pkg::hall_t'(code));
		write_command(16'd100);
		for (int code = 0; code < 8; code++)
			send_word(bhcs_pkg::OP_HALL, bhcs_pkg::hall_t'(code));
		// close a window with rotations counted in between
		for (int i = 0; i < 10; i++) begin
			if (i % 3 == 0)
				send_word(bhcs_pkg::OP_HALL, 3'd2);
			send_word(bhcs_pkg::OP_TICK, bhcs_pkg::hall_t'($urandom_range(0, 7)));
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			write_command(plan[phase]);
			send_burst = (phase % 3 == 1);
			take_burst = (phase % 4 == 2);
			position   = $urandom_range(0, 5);
			forward    = $urandom_range(0, 1);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					// step the rotor one sector, mostly in one direction
					if ($urandom_range(0, 19) == 0)
						forward = !forward;
					position = (position + (forward ? 1 : 5)) % 6;
					send_word(bhcs_pkg::OP_HALL, TURN[position*3 +: 3]);
				end else if (pick < 85) begin
					send_word(bhcs_pkg::OP_TICK, bhcs_pkg::hall_t'($urandom_range(0, 7)));
				end else begin
					send_word(bhcs_pkg::OP_HALL, bhcs_pkg::hall_t'($urandom_range(0, 7)));
				end
			end
		end

		s_tvalid <= 1'b0;
		while (awaiting != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
